// ===== rtl/cau_pkg.sv =====
// shared types, constants and helpers for the complex arithmetic unit
package cau_pkg;

  localparam int unsigned DIV_STEPS  = 48;
  localparam int unsigned SQRT_STEPS = 25;

  typedef enum logic [2:0] {
    ACT_ADD  = 3'd0,
    ACT_SUB  = 3'd1,
    ACT_MUL  = 3'd2,
    ACT_DIV  = 3'd3,
    ACT_DIST = 3'd4
  } action_t;

  typedef struct packed {
    logic               vld;
    logic [2:0]         act;
    logic signed [31:0] pre_re;
    logic signed [31:0] pre_im;
    logic               pre_sat;
    logic               dz;
    logic               neg_r;
    logic               neg_i;
    logic [31:0]        den;
    logic [31:0]        rem_r;
    logic [31:0]        rem_i;
    logic [47:0]        dq_r;
    logic [47:0]        dq_i;
    logic [49:0]        srad;
    logic [25:0]        srem;
    logic [24:0]        sroot;
  } cell_t;

  // saturate a 33-bit signed value to 32 bits, sat flag on top
  function automatic logic [32:0] clamp33(input logic signed [32:0] x);
    logic [32:0] r;
    begin
      if (x[32] != x[31]) begin
        r = x[32] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7fff_ffff};
      end else begin
        r = {1'b0, x[31:0]};
      end
      return r;
    end
  endfunction

  // apply sign to a quotient magnitude and saturate, sat flag on top
  function automatic logic [32:0] fix_q(input logic neg, input logic [47:0] q);
    logic [32:0] r;
    logic [31:0] nq;
    begin
      nq = ~q[31:0] + 32'd1;
      if (neg) begin
        if (q > 48'h0000_8000_0000) r = {1'b1, 32'h8000_0000};
        else r = {1'b0, nq};
      end else begin
        if (q > 48'h0000_7fff_ffff) r = {1'b1, 32'h7fff_ffff};
        else r = {1'b0, q[31:0]};
      end
      return r;
    end
  endfunction

endpackage

// ===== rtl/cau_if.sv =====
// item channel interfaces of the complex arithmetic unit
interface cau_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic signed [15:0] a_real;
  logic signed [15:0] a_imag;
  logic signed [15:0] b_real;
  logic signed [15:0] b_imag;
  modport source (output valid, action, a_real, a_imag, b_real, b_imag, input ready);
  modport sink (input valid, action, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_real;
  logic signed [31:0] res_imag;
  logic               div_by_zero;
  logic               saturated;
  modport source (output valid, res_real, res_imag, div_by_zero, saturated, input ready);
  modport sink (input valid, res_real, res_imag, div_by_zero, saturated, output ready);
endinterface

// ===== rtl/cau_cell.sv =====
// one cell of the chain: a divide step on both parts and an optional square root step
module cau_cell #(
  parameter bit SQRT_EN = 1'b1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  cau_pkg::cell_t c_in,
  output cau_pkg::cell_t c_out
);

  cau_pkg::cell_t c_nxt;
  logic [32:0] t_r, t_i, d33;
  logic        b_r, b_i;
  logic [27:0] s_rem, s_trial;
  logic        s_bit;

  always_comb begin
    c_nxt = c_in;
    d33 = {1'b0, c_in.den};
    t_r = {c_in.rem_r, c_in.dq_r[47]};
    t_i = {c_in.rem_i, c_in.dq_i[47]};
    b_r = (t_r >= d33);
    b_i = (t_i >= d33);
    c_nxt.rem_r = b_r ? 32'(t_r - d33) : t_r[31:0];
    c_nxt.rem_i = b_i ? 32'(t_i - d33) : t_i[31:0];
    c_nxt.dq_r = {c_in.dq_r[46:0], b_r};
    c_nxt.dq_i = {c_in.dq_i[46:0], b_i};
    s_rem = {c_in.srem, c_in.srad[49:48]};
    s_trial = {1'b0, c_in.sroot, 2'b01};
    s_bit = (s_rem >= s_trial);
    if (SQRT_EN) begin
      c_nxt.srad = {c_in.srad[47:0], 2'b00};
      c_nxt.srem = s_bit ? 26'(s_rem - s_trial) : s_rem[25:0];
      c_nxt.sroot = {c_in.sroot[23:0], s_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_out.vld <= 1'b0;
    end else if (en) begin
      c_out <= c_nxt;
    end
  end

endmodule

// ===== rtl/complex_arithmetic_unit.sv =====
// top level of the complex arithmetic unit: operand stages, cell chain, output register
//
//   channel  dir  payload
//   in_ch    in   action, a_real, a_imag, b_real, b_imag (Q8.8)
//   out_ch   out  res_real, res_imag (Q16.16), div_by_zero, saturated
//
// one item per cycle while the output is not stalled; three operand stages, 48 chain cells
// (one quotient bit each, the first 25 also one root bit), one output register
// reset clears the valid bits only
// a stalled output holds the whole pipeline; in_ch.ready follows the output register
module complex_arithmetic_unit (
  input logic       clk,
  input logic       rst_n,
  cau_in_if.sink    in_ch,
  cau_out_if.source out_ch
);

  logic en;

  logic               s1_vld_r;
  logic [2:0]         s1_act_r;
  logic signed [31:0] s1_pre_r;
  logic signed [31:0] s1_pim_r;
  logic signed [31:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, sq_br_r, sq_bi_r;
  logic signed [33:0] sq_dr_r, sq_di_r;
  logic signed [16:0] sum_r, sum_i, dif_r, dif_i;

  logic               s2_vld_r;
  logic [2:0]         s2_act_r;
  logic signed [31:0] s2_pre_r, s2_pim_r;
  logic signed [32:0] mre_r, mim_r, nr_r, ni_r;
  logic [31:0]        m_r;
  logic [33:0]        s_r;

  cau_pkg::cell_t c0_nxt;
  cau_pkg::cell_t c0_r;
  cau_pkg::cell_t chain [cau_pkg::DIV_STEPS+1];
  logic [32:0] cre, cim;
  logic [31:0] mag_r, mag_i;

  logic               out_v_r;
  logic signed [31:0] o_re_r, o_im_r, o_re_nxt, o_im_nxt;
  logic               o_dz_r, o_sat_r, o_dz_nxt, o_sat_nxt;
  logic [32:0]        qr, qi;
  logic [25:0]        root;
  cau_pkg::cell_t     cl;

  assign en = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  assign sum_r = {in_ch.a_real[15], in_ch.a_real} + {in_ch.b_real[15], in_ch.b_real};
  assign sum_i = {in_ch.a_imag[15], in_ch.a_imag} + {in_ch.b_imag[15], in_ch.b_imag};
  assign dif_r = {in_ch.a_real[15], in_ch.a_real} - {in_ch.b_real[15], in_ch.b_real};
  assign dif_i = {in_ch.a_imag[15], in_ch.a_imag} - {in_ch.b_imag[15], in_ch.b_imag};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_ch.valid;
      s2_vld_r <= s1_vld_r;
      out_v_r  <= cl.vld;
    end
  end

  // operand stage: sum or difference, products and squares
  always_ff @(posedge clk) begin
    if (en) begin
      s1_act_r <= in_ch.action;
      if (in_ch.action == cau_pkg::ACT_ADD) begin
        s1_pre_r <= {{7{sum_r[16]}}, sum_r, 8'h00};
        s1_pim_r <= {{7{sum_i[16]}}, sum_i, 8'h00};
      end else begin
        s1_pre_r <= {{7{dif_r[16]}}, dif_r, 8'h00};
        s1_pim_r <= {{7{dif_i[16]}}, dif_i, 8'h00};
      end
      p_rr_r  <= in_ch.a_real * in_ch.b_real;
      p_ii_r  <= in_ch.a_imag * in_ch.b_imag;
      p_ri_r  <= in_ch.a_real * in_ch.b_imag;
      p_ir_r  <= in_ch.a_imag * in_ch.b_real;
      sq_br_r <= in_ch.b_real * in_ch.b_real;
      sq_bi_r <= in_ch.b_imag * in_ch.b_imag;
      sq_dr_r <= dif_r * dif_r;
      sq_di_r <= dif_i * dif_i;
    end
  end

  // sum stage
  always_ff @(posedge clk) begin
    if (en) begin
      s2_act_r <= s1_act_r;
      s2_pre_r <= s1_pre_r;
      s2_pim_r <= s1_pim_r;
      mre_r <= 33'(p_rr_r) - 33'(p_ii_r);
      mim_r <= 33'(p_ri_r) + 33'(p_ir_r);
      nr_r  <= 33'(p_rr_r) + 33'(p_ii_r);
      ni_r  <= 33'(p_ir_r) - 33'(p_ri_r);
      m_r   <= 32'(sq_br_r) + 32'(sq_bi_r);
      s_r   <= 34'(sq_dr_r) + 34'(sq_di_r);
    end
  end

  // chain entry
  always_comb begin
    cre = cau_pkg::clamp33(mre_r);
    cim = cau_pkg::clamp33(mim_r);
    mag_r = nr_r[32] ? 32'(-nr_r) : nr_r[31:0];
    mag_i = ni_r[32] ? 32'(-ni_r) : ni_r[31:0];
    c0_nxt = '0;
    c0_nxt.vld = s2_vld_r;
    c0_nxt.act = s2_act_r;
    case (s2_act_r)
      cau_pkg::ACT_ADD, cau_pkg::ACT_SUB: begin
        c0_nxt.pre_re = s2_pre_r;
        c0_nxt.pre_im = s2_pim_r;
      end
      cau_pkg::ACT_MUL: begin
        c0_nxt.pre_re  = cre[31:0];
        c0_nxt.pre_im  = cim[31:0];
        c0_nxt.pre_sat = cre[32] | cim[32];
      end
      default: begin
        c0_nxt.pre_re = '0;
        c0_nxt.pre_im = '0;
      end
    endcase
    c0_nxt.dz    = (m_r == 32'd0);
    c0_nxt.neg_r = nr_r[32];
    c0_nxt.neg_i = ni_r[32];
    c0_nxt.den   = m_r;
    c0_nxt.dq_r  = {mag_r, 16'h0000} + 48'(m_r[31:1]);
    c0_nxt.dq_i  = {mag_i, 16'h0000} + 48'(m_r[31:1]);
    c0_nxt.srad  = {s_r, 16'h0000};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_r.vld <= 1'b0;
    end else if (en) begin
      c0_r <= c0_nxt;
    end
  end

  assign chain[0] = c0_r;

  for (genvar g = 0; g < cau_pkg::DIV_STEPS; g++) begin : g_cell
    cau_cell #(
      .SQRT_EN(g < cau_pkg::SQRT_STEPS)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .c_in  (chain[g]),
      .c_out (chain[g+1])
    );
  end

  // result select
  assign cl = chain[cau_pkg::DIV_STEPS];

  always_comb begin
    qr = cau_pkg::fix_q(cl.neg_r, cl.dq_r);
    qi = cau_pkg::fix_q(cl.neg_i, cl.dq_i);
    root = {1'b0, cl.sroot} + 26'({25'd0, cl.srem > {1'b0, cl.sroot}});
    o_re_nxt  = '0;
    o_im_nxt  = '0;
    o_dz_nxt  = 1'b0;
    o_sat_nxt = 1'b0;
    case (cl.act)
      cau_pkg::ACT_ADD, cau_pkg::ACT_SUB, cau_pkg::ACT_MUL: begin
        o_re_nxt  = cl.pre_re;
        o_im_nxt  = cl.pre_im;
        o_sat_nxt = cl.pre_sat;
      end
      cau_pkg::ACT_DIV: begin
        if (cl.dz) begin
          o_dz_nxt = 1'b1;
        end else begin
          o_re_nxt  = qr[31:0];
          o_im_nxt  = qi[31:0];
          o_sat_nxt = qr[32] | qi[32];
        end
      end
      cau_pkg::ACT_DIST: begin
        o_re_nxt = {6'd0, root};
      end
      default: begin
        o_re_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_re_r  <= o_re_nxt;
      o_im_r  <= o_im_nxt;
      o_dz_r  <= o_dz_nxt;
      o_sat_r <= o_sat_nxt;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.res_real    = o_re_r;
  assign out_ch.res_imag    = o_im_r;
  assign out_ch.div_by_zero = o_dz_r;
  assign out_ch.saturated   = o_sat_r;

  a_no_take_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |-> !in_ch.ready)
    else $error("item taken while output blocked");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && o_dz_r |-> o_re_r == 32'sd0 && o_im_r == 32'sd0 && !o_sat_r)
    else $error("zero divisor result not cleared");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    en && in_ch.valid |=> s1_vld_r)
    else $error("accepted item lost at entry");

endmodule
